FILE: rtl/pbu_pkg.sv
// Shared types, character codes and helpers for the percent/backslash unescape unit.
`default_nettype none
package pbu_pkg;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_N   = 8'h6E;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HEX1 = 2'd2;

    // Result queue depth and pointer width
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
        logic       malformed;
    } out_item_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] nibble;
        logic       bsl_pend;
        logic       trunc;
        logic       err;
    } dec_state_t;

    // Results produced by one item: 0..2 entries
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             room;
    } fifo_status_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
            r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h41:8'h46]})
            r = {1'b1, 4'(b - 8'h37)};
        else if (b inside {[8'h61:8'h66]})
            r = {1'b1, 4'(b - 8'h57)};
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pbu_decode.sv
// Escape decoder: state registers and the per-item two-stage decode.
`default_nettype none
module pbu_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire pbu_pkg::in_item_t item,
    output pbu_pkg::push_t        push
);
    import pbu_pkg::*;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } emit_t;

    dec_state_t state_reg;
    dec_state_t state_next;

    function automatic void put_byte(input logic [7:0] b, inout dec_state_t s, inout emit_t e);
        if (!(s.trunc || s.err)) begin
            if (b == 8'h00) begin
                s.trunc = 1'b1;
            end
            else begin
                if (e.cnt == 2'd0)
                    e.b0 = b;
                else
                    e.b1 = b;
                e.cnt = e.cnt + 2'd1;
            end
        end
    endfunction

    function automatic void stage_two(input logic [7:0] b, inout dec_state_t s, inout emit_t e);
        logic done;
        done = 1'b0;
        if (s.bsl_pend) begin
            s.bsl_pend = 1'b0;
            if (b == CH_BSL) begin
                put_byte(CH_BSL, s, e);
                done = 1'b1;
            end
            else if (b == CH_N) begin
                put_byte(CH_NL, s, e);
                done = 1'b1;
            end
            else begin
                put_byte(CH_BSL, s, e);
            end
        end
        if (!done) begin
            if (b == CH_BSL && !s.trunc && !s.err)
                s.bsl_pend = 1'b1;
            else
                put_byte(b, s, e);
        end
    endfunction

    always_comb
    begin
        dec_state_t s;
        emit_t      e;
        logic [4:0] h;
        logic       mal;
        logic [1:0] n;

        s   = state_reg;
        e   = '0;
        mal = 1'b0;
        h   = hex_val(item.in_byte);

        case (s.phase)
            ESC_PCT:
            begin
                s.phase = ESC_IDLE;
                if (item.in_byte == CH_PCT) begin
                    stage_two(CH_PCT, s, e);
                end
                else if (!h[4]) begin
                    s.err = 1'b1;
                end
                else begin
                    s.nibble = h[3:0];
                    s.phase  = ESC_HEX1;
                end
            end
            ESC_HEX1:
            begin
                s.phase = ESC_IDLE;
                if (!h[4])
                    s.err = 1'b1;
                else
                    stage_two({s.nibble, h[3:0]}, s, e);
            end
            default:
            begin
                s.phase = ESC_IDLE;
                if (item.in_byte == CH_PCT)
                    s.phase = ESC_PCT;
                else
                    stage_two(item.in_byte, s, e);
            end
        endcase

        if (item.in_last) begin
            if (s.phase != ESC_IDLE)
                s.err = 1'b1;
            if (s.bsl_pend) begin
                s.bsl_pend = 1'b0;
                put_byte(CH_BSL, s, e);
            end
            mal = s.err;
        end

        // a message end always yields at least one result
        n = e.cnt;
        if (item.in_last && n == 2'd0)
            n = 2'd1;

        push.cnt                = n;
        push.item0.out_byte     = (e.cnt != 2'd0) ? e.b0 : 8'h00;
        push.item0.byte_valid   = (e.cnt != 2'd0);
        push.item0.message_end  = item.in_last && (n == 2'd1);
        push.item0.malformed    = mal && (n == 2'd1);
        push.item1.out_byte     = e.b1;
        push.item1.byte_valid   = 1'b1;
        push.item1.message_end  = item.in_last;
        push.item1.malformed    = mal;

        state_next = item.in_last ? '0 : s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (fire)
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

FILE: rtl/pbu_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per handshake.
`default_nettype none
module pbu_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_en,
    input  wire pbu_pkg::push_t       push,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pbu_pkg::out_item_t        out_data,
    output pbu_pkg::fifo_status_t     status
);
    import pbu_pkg::*;

    out_item_t        mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n    = push_en ? push.cnt : 2'd0;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    // room for a worst-case item regardless of this cycle's pop
    assign status.count = count_reg;
    assign status.room  = (count_reg <= CNT_W'(OUT_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= push.item0;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.item1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/percent_backslash_unescape_unit.sv
// Top level of the percent/backslash unescape unit.
// Takes one raw message byte per item and decodes "%%" and "%XY" escapes, then "\\" and
// "\n" on the decoded stream. Each item yields zero, one or two results; the last byte
// of a message always yields at least one, carrying message_end and malformed. A byte
// is registered on input and decoded from that register into a four-entry result
// queue once the queue has room, and one item is accepted per cycle as long as the
// queue has room for two results; items producing two results can back up the input
// when the output side takes only one result per cycle.
`default_nettype none
module percent_backslash_unescape_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pbu_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pbu_pkg::out_item_t      out_data
);
    import pbu_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    logic         fire;
    push_t        push;
    fifo_status_t fifo_st;

    assign fire     = in_valid_reg && fifo_st.room;
    assign in_ready = !in_valid_reg || fifo_st.room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    pbu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    pbu_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (fifo_st)
    );

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.count <= CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.message_end && out_data.out_byte == 8'h00)
        else $error("empty result not at message end");

    a_mal_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.malformed |-> out_data.message_end)
        else $error("malformed flag outside message end");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fifo_st.room |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending item lost while stalled");

endmodule
`default_nettype wire
